[sv/cbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

    // Widths of counters, column tracking and the register fields.
    localparam int COUNT_BITS  = 24;
    localparam int COLUMN_BITS = 12;
    localparam int WIDTH_BITS  = 12;
    localparam int TOTAL_BITS  = 24;
    localparam int SPEED_BITS  = 8;
    localparam int ANGLE_BITS  = 9;
    localparam int COLOR_BITS  = 8;
    localparam int SUM_BITS    = COUNT_BITS + 2;
    localparam int CMP_BITS    = ((COLUMN_BITS > WIDTH_BITS) ? COLUMN_BITS : WIDTH_BITS) + 1;

    // Configuration port shape.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_TOTAL     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_TOTAL     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_SPEED = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_RATE     = 3'd4;

    // Register reset values.
    localparam int RESET_FRAME_WIDTH   = 640;
    localparam int RESET_MIN_TOTAL     = 100;
    localparam int RESET_MAX_TOTAL     = 40000;
    localparam int RESET_FORWARD_SPEED = 102;
    localparam int RESET_TURN_RATE     = 128;
    localparam int RESET_THIRD         = RESET_FRAME_WIDTH / 3;
    localparam int RESET_MID_LIMIT     = RESET_FRAME_WIDTH - RESET_THIRD;

    // Reciprocal of three in 16 fractional bits; exact floor for 12-bit widths.
    localparam int RECIP_BITS  = 15;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_BITS-1:0] RECIP_THREE = 15'd21846;

    // Component levels of the pure yellow reference color.
    localparam logic [COLOR_BITS-1:0] COLOR_FULL = '1;
    localparam logic [COLOR_BITS-1:0] COLOR_NONE = '0;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

[sv/cbs_pixel_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pixel stream channel.
interface cbs_pixel_if;
    import cbs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

`default_nettype wire

[sv/cbs_drive_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Drive command channel.
interface cbs_drive_if;
    import cbs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [SPEED_BITS-1:0]        linear_speed;
    logic signed [ANGLE_BITS-1:0] angular_speed;

    modport source (output valid, linear_speed, angular_speed, input ready);
    modport sink   (input valid, linear_speed, angular_speed, output ready);
endinterface

`default_nettype wire

[sv/color_blob_steering.sv]
`timescale 1ns / 1ps
`default_nettype none

// Yellow blob steering block.
// Pixels enter in raster order on the pixel channel (valid/ready), one per
// clock unless ready is low; frame_end marks the last pixel of a frame. Each
// pixel is classified into the left, middle or right third of the row and
// pure-yellow pixels bump a saturating counter for that third.
// On a frame end the counts pass through two evaluation stages and a drive
// command lands in the output register after the frame-end transaction has
// passed stages 1, 2 and 3. The command is offered on the drive channel only
// when it differs from the previous command.
// Throughput is one pixel per cycle except while the pixel stream is held
// off. Only a frame-end pixel waits in stage 1 on the drive channel, and it
// holds off the stream only while the evaluation stages and the output
// register are all full because the receiver stalls.
// The user writes registers through cfg_we/cfg_index/cfg_data only while the
// block is idle (not enforced); a write to an unlisted index is ignored.
// Reset restores the register defaults, clears the counters, the column and
// the remembered command (0, 0), and empties the pipeline.
module color_blob_steering (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [cbs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [cbs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    cbs_pixel_if.sink                                pixel,
    cbs_drive_if.source                              drive
);
    import cbs_pkg::*;

    // Configuration registers.
    logic [WIDTH_BITS-1:0] frame_width_reg;
    logic [TOTAL_BITS-1:0] min_total_reg;
    logic [TOTAL_BITS-1:0] max_total_reg;
    logic [SPEED_BITS-1:0] forward_speed_reg;
    logic [SPEED_BITS-1:0] turn_rate_reg;

    // Region bounds derived from the frame width.
    logic [WIDTH_BITS+RECIP_BITS-1:0] third_prod;
    logic [WIDTH_BITS-1:0]            third_next;
    logic [WIDTH_BITS-1:0]            third_reg;
    logic [WIDTH_BITS-1:0]            mid_limit_reg;

    // Column tracking.
    logic [COLUMN_BITS-1:0] column_pos_reg;
    logic [COLUMN_BITS-1:0] column_pos_next;
    logic [CMP_BITS-1:0]    col_ext;
    logic [CMP_BITS-1:0]    col_inc;

    // Stage 1: classified pixel.
    logic s1_valid_reg;
    logic s1_left_reg;
    logic s1_mid_reg;
    logic s1_right_reg;
    logic s1_last_reg;
    logic is_yellow;
    logic in_left;
    logic in_mid;

    // Hit counters.
    logic [COUNT_BITS-1:0] left_hits_reg;
    logic [COUNT_BITS-1:0] middle_hits_reg;
    logic [COUNT_BITS-1:0] right_hits_reg;
    logic [COUNT_BITS-1:0] left_hits_next;
    logic [COUNT_BITS-1:0] middle_hits_next;
    logic [COUNT_BITS-1:0] right_hits_next;

    // Stage 2: final counts of a frame.
    logic                  s2_valid_reg;
    logic [COUNT_BITS-1:0] s2_left_reg;
    logic [COUNT_BITS-1:0] s2_mid_reg;
    logic [COUNT_BITS-1:0] s2_right_reg;

    // Stage 3: total and dominance.
    logic                s3_valid_reg;
    logic [SUM_BITS-1:0] s3_total_reg;
    logic                s3_left_wins_reg;
    logic                s3_mid_wins_reg;

    // Command and output register.
    logic [SPEED_BITS-1:0]        lin_next;
    logic [ANGLE_BITS-1:0]        ang_next;
    logic                         differs;
    logic [SPEED_BITS-1:0]        prev_linear_reg;
    logic [ANGLE_BITS-1:0]        prev_angular_reg;
    logic                         out_valid_reg;
    logic [SPEED_BITS-1:0]        out_linear_reg;
    logic [ANGLE_BITS-1:0]        out_angular_reg;

    // Stage advance controls.
    logic s1_go;
    logic s2_go;
    logic s3_go;
    logic in_take;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= WIDTH_BITS'(RESET_FRAME_WIDTH);
            min_total_reg     <= TOTAL_BITS'(RESET_MIN_TOTAL);
            max_total_reg     <= TOTAL_BITS'(RESET_MAX_TOTAL);
            forward_speed_reg <= SPEED_BITS'(RESET_FORWARD_SPEED);
            turn_rate_reg     <= SPEED_BITS'(RESET_TURN_RATE);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[WIDTH_BITS-1:0];
                REG_MIN_TOTAL:     min_total_reg     <= cfg_data[TOTAL_BITS-1:0];
                REG_MAX_TOTAL:     max_total_reg     <= cfg_data[TOTAL_BITS-1:0];
                REG_FORWARD_SPEED: forward_speed_reg <= cfg_data[SPEED_BITS-1:0];
                REG_TURN_RATE:     turn_rate_reg     <= cfg_data[SPEED_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Third of the written width by multiplying with the reciprocal of three.
    assign third_prod = cfg_data[WIDTH_BITS-1:0] * RECIP_THREE;
    assign third_next = WIDTH_BITS'(third_prod >> RECIP_SHIFT);

    // Region bounds change together with the frame width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            third_reg     <= WIDTH_BITS'(RESET_THIRD);
            mid_limit_reg <= WIDTH_BITS'(RESET_MID_LIMIT);
        end
        else if (cfg_we && (cfg_index == REG_FRAME_WIDTH))
        begin
            third_reg     <= third_next;
            mid_limit_reg <= cfg_data[WIDTH_BITS-1:0] - third_next;
        end
    end

    // Handshake chain: ordinary pixels drop out after stage 1.
    assign s3_go    = !out_valid_reg || drive.ready;
    assign s2_go    = !s3_valid_reg || s3_go;
    assign s1_go    = !s1_last_reg || !s2_valid_reg || s2_go;
    assign in_take  = !s1_valid_reg || s1_go;
    assign pixel.ready = in_take;

    // Classification of the incoming pixel.
    assign is_yellow = (pixel.red == COLOR_FULL) && (pixel.green == COLOR_FULL)
                    && (pixel.blue == COLOR_NONE);
    assign col_ext   = CMP_BITS'(column_pos_reg);
    assign col_inc   = col_ext + CMP_BITS'(1);
    assign in_left   = col_ext < CMP_BITS'(third_reg);
    assign in_mid    = col_ext < CMP_BITS'(mid_limit_reg);

    // Column wraps at the frame width and restarts after a frame end.
    always_comb
    begin
        if (pixel.frame_end || (col_inc >= CMP_BITS'(frame_width_reg)))
            column_pos_next = '0;
        else
            column_pos_next = COLUMN_BITS'(col_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_pos_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_left_reg    <= 1'b0;
            s1_mid_reg     <= 1'b0;
            s1_right_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= pixel.valid;
            if (pixel.valid)
            begin
                column_pos_reg <= column_pos_next;
                s1_left_reg    <= is_yellow && in_left;
                s1_mid_reg     <= is_yellow && !in_left && in_mid;
                s1_right_reg   <= is_yellow && !in_left && !in_mid;
                s1_last_reg    <= pixel.frame_end;
            end
            else
            begin
                s1_last_reg <= 1'b0;
            end
        end
    end

    // Saturating counter increments.
    assign left_hits_next   = (s1_left_reg && (left_hits_reg != COUNT_MAX))
                            ? left_hits_reg + COUNT_BITS'(1) : left_hits_reg;
    assign middle_hits_next = (s1_mid_reg && (middle_hits_reg != COUNT_MAX))
                            ? middle_hits_reg + COUNT_BITS'(1) : middle_hits_reg;
    assign right_hits_next  = (s1_right_reg && (right_hits_reg != COUNT_MAX))
                            ? right_hits_reg + COUNT_BITS'(1) : right_hits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_hits_reg   <= '0;
            middle_hits_reg <= '0;
            right_hits_reg  <= '0;
        end
        else if (s1_valid_reg && s1_go)
        begin
            if (s1_last_reg)
            begin
                left_hits_reg   <= '0;
                middle_hits_reg <= '0;
                right_hits_reg  <= '0;
            end
            else
            begin
                left_hits_reg   <= left_hits_next;
                middle_hits_reg <= middle_hits_next;
                right_hits_reg  <= right_hits_next;
            end
        end
    end

    // Stage 2 captures the final counts of a frame and holds them until stage 3 is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_last_reg && s1_go)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_last_reg && s1_go)
        begin
            s2_left_reg  <= left_hits_next;
            s2_mid_reg   <= middle_hits_next;
            s2_right_reg <= right_hits_next;
        end
    end

    // Stage 3 forms the total and decides which third dominates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_go)
        begin
            s3_total_reg     <= SUM_BITS'(s2_left_reg) + SUM_BITS'(s2_mid_reg)
                              + SUM_BITS'(s2_right_reg);
            s3_left_wins_reg <= (s2_left_reg >= s2_mid_reg) && (s2_left_reg >= s2_right_reg);
            s3_mid_wins_reg  <= s2_mid_reg >= s2_right_reg;
        end
    end

    // Command from the bounds check and the dominant third.
    always_comb
    begin
        if ((s3_total_reg > SUM_BITS'(max_total_reg)) || (s3_total_reg < SUM_BITS'(min_total_reg)))
            lin_next = '0;
        else
            lin_next = forward_speed_reg;

        if (s3_left_wins_reg)
            ang_next = ANGLE_BITS'(turn_rate_reg);
        else if (s3_mid_wins_reg)
            ang_next = '0;
        else
            ang_next = '0 - ANGLE_BITS'(turn_rate_reg);
    end

    assign differs = (lin_next != prev_linear_reg) || (ang_next != prev_angular_reg);

    // Remembered command and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_linear_reg  <= '0;
            prev_angular_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else if (s3_valid_reg && s3_go)
        begin
            prev_linear_reg  <= lin_next;
            prev_angular_reg <= ang_next;
            out_valid_reg    <= differs;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_go && differs)
        begin
            out_linear_reg  <= lin_next;
            out_angular_reg <= ang_next;
        end
    end

    assign drive.valid         = out_valid_reg;
    assign drive.linear_speed  = out_linear_reg;
    assign drive.angular_speed = $signed(out_angular_reg);

    // A yellow pixel falls into at most one third.
    a_one_region: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_left_reg, s1_mid_reg, s1_right_reg}))
        else $error("pixel classified into more than one third");

    // Counters restart after a frame end leaves stage 1.
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && s1_go) |=>
        (left_hits_reg == '0 && middle_hits_reg == '0 && right_hits_reg == '0))
        else $error("hit counters not cleared after frame end");

    // A pending command always equals the remembered one.
    a_out_matches_prev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_linear_reg == prev_linear_reg
                           && out_angular_reg == prev_angular_reg))
        else $error("pending command differs from remembered command");

    // Only a waiting frame-end pixel may hold off the pixel stream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_take |-> (s1_valid_reg && s1_last_reg && s2_valid_reg))
        else $error("pixel stream stalled without a waiting frame end");

endmodule

`default_nettype wire

[tb/tb_color_blob_steering.sv]
`timescale 1ns / 1ps

module tb_color_blob_steering;
    import cbs_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_WAIT      = 8;
    localparam int RANDOM_PIXELS = 2000;
    localparam int LONG_STALL    = 600;
    localparam int STALL_AFTER   = 25;
    localparam int SETTLE_CYCLES = 12;

    // How a row of the directed plan is checked.
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_VALUE} check_e;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic                  frame_end;
    } pixel_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0]        linear_speed;
        logic signed [ANGLE_BITS-1:0] angular_speed;
    } drive_cmd_t;

    typedef struct packed {
        logic       reconfig;
        logic [11:0] copies;
        pixel_t     px;
        check_e     check;
        drive_cmd_t cmd;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    cbs_pixel_if pixel();
    cbs_drive_if drive();

    color_blob_steering uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .drive     (drive)
    );

    // Register copies and tracking state of the steering predictor.
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [TOTAL_BITS-1:0]  min_reg;
    logic [TOTAL_BITS-1:0]  max_reg;
    logic [SPEED_BITS-1:0]  forward_reg;
    logic [SPEED_BITS-1:0]  turn_reg;
    logic [COLUMN_BITS-1:0] column;
    logic [COUNT_BITS-1:0]  hits_left;
    logic [COUNT_BITS-1:0]  hits_middle;
    logic [COUNT_BITS-1:0]  hits_right;
    drive_cmd_t             last_cmd;

    drive_cmd_t pending_cmds[$];
    int         fault_count = 0;
    int         results_seen = 0;
    int         random_pixels = 0;
    bit         quiet_phase = 1'b0;
    bit         stall_done = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    // Counts one pixel into its third and forms the command on a frame end.
    task automatic track_pixel(input pixel_t px, output bit emits, output drive_cmd_t cmd);
        logic [WIDTH_BITS-1:0] third;
        int                    total;
        third = width_reg / 3;
        emits = 1'b0;
        cmd   = last_cmd;
        if (px.red == COLOR_FULL && px.green == COLOR_FULL && px.blue == COLOR_NONE) begin
            if (column < third)
            begin
                if (hits_left != COUNT_MAX)
                    hits_left++;
            end
            else if (column < width_reg - third)
            begin
                if (hits_middle != COUNT_MAX)
                    hits_middle++;
            end
            else if (hits_right != COUNT_MAX)
            begin
                hits_right++;
            end
        end
        if (int'(column) + 1 >= int'(width_reg))
            column = '0;
        else
            column = column + 1'b1;

        if (px.frame_end) begin
            total = hits_left + hits_middle + hits_right;
            cmd.linear_speed = (total > max_reg || total < min_reg) ? '0 : forward_reg;
            if (hits_left >= hits_middle && hits_left >= hits_right)
                cmd.angular_speed = {1'b0, turn_reg};
            else if (hits_middle >= hits_right)
                cmd.angular_speed = '0;
            else
                cmd.angular_speed = -{1'b0, turn_reg};
            emits       = (cmd != last_cmd);
            last_cmd    = cmd;
            column      = '0;
            hits_left   = '0;
            hits_middle = '0;
            hits_right  = '0;
        end
    endtask

    // One register write; the predictor copy follows at once since the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_FRAME_WIDTH:   width_reg   = data[WIDTH_BITS-1:0];
            REG_MIN_TOTAL:     min_reg     = data[TOTAL_BITS-1:0];
            REG_MAX_TOTAL:     max_reg     = data[TOTAL_BITS-1:0];
            REG_FORWARD_SPEED: forward_reg = data[SPEED_BITS-1:0];
            REG_TURN_RATE:     turn_reg    = data[SPEED_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [WIDTH_BITS-1:0] width,
                                  input logic [TOTAL_BITS-1:0] min_total,
                                  input logic [TOTAL_BITS-1:0] max_total,
                                  input logic [SPEED_BITS-1:0] forward,
                                  input logic [SPEED_BITS-1:0] turn);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(width));
        write_reg(REG_MIN_TOTAL, min_total);
        write_reg(REG_MAX_TOTAL, max_total);
        write_reg(REG_FORWARD_SPEED, CFG_DATA_BITS'(forward));
        write_reg(REG_TURN_RATE, CFG_DATA_BITS'(turn));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one pixel after a random gap and predicts once the transaction completes.
    task automatic send_pixel(input pixel_t px, output bit emits, output drive_cmd_t cmd);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0) begin
            pixel.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel.valid     <= 1'b1;
        pixel.red       <= px.red;
        pixel.green     <= px.green;
        pixel.blue      <= px.blue;
        pixel.frame_end <= px.frame_end;
        do
            @(posedge clk);
        while (!pixel.ready);
        track_pixel(px, emits, cmd);
    endtask

    // Stops the pixel stream and lets every outstanding command drain.
    task automatic settle_block();
        @(negedge clk);
        pixel.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [TOTAL_BITS-1:0] draw_bound(input int span);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            5:       return TOTAL_BITS'($urandom);
            default: return TOTAL_BITS'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [SPEED_BITS-1:0] draw_speed();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return SPEED_BITS'($urandom);
        endcase
    endfunction

    function automatic plan_row_t plan_row(input logic reconfig, input int copies,
                                           input logic [23:0] rgb, input logic frame_end,
                                           input check_e check,
                                           input logic [SPEED_BITS-1:0] linear,
                                           input logic signed [ANGLE_BITS-1:0] angular);
        plan_row_t row;
        row.reconfig          = reconfig;
        row.copies            = 12'(copies);
        row.px                = {rgb, frame_end};
        row.check             = check;
        row.cmd.linear_speed  = linear;
        row.cmd.angular_speed = angular;
        return row;
    endfunction

    // One random configuration followed by a run of frames with biased yellow content.
    task automatic run_random_phase();
        logic [WIDTH_BITS-1:0] width;
        logic [WIDTH_BITS-1:0] third;
        int                    frames;
        int                    span;
        int                    length;
        int                    region;
        int                    odds[3];
        pixel_t                px;
        bit                    emits;
        drive_cmd_t            cmd;
        case ($urandom_range(0, 9))
            0:       width = WIDTH_BITS'($urandom_range(0, 2));
            1:       width = '1;
            2:       width = WIDTH_BITS'(RESET_FRAME_WIDTH);
            3:       width = WIDTH_BITS'($urandom_range(33, 4095));
            default: width = WIDTH_BITS'($urandom_range(3, 16));
        endcase
        span = (width < 3) ? 12 : ((width > 16) ? 48 : 3 * width);
        apply_settings(width, draw_bound(span), draw_bound(span), draw_speed(), draw_speed());
        quiet_phase = ($urandom_range(0, 4) == 0);
        frames = $urandom_range(6, 14);

        for (int f = 0; f < frames; f++) begin
            for (int r = 0; r < 3; r++) begin
                case ($urandom_range(0, 4))
                    0:       odds[r] = 0;
                    1:       odds[r] = 100;
                    2:       odds[r] = 50;
                    default: odds[r] = $urandom_range(0, 100);
                endcase
            end
            // Now and then a full row at widths of 3 to 700, so the row reaches all thirds.
            if (width >= 3 && width <= 700 && $urandom_range(0, 19) == 0)
                length = width;
            else
                length = $urandom_range(1, span);

            for (int i = 0; i < length; i++) begin
                third = width_reg / 3;
                if (column < third)
                    region = 0;
                else if (column < width_reg - third)
                    region = 1;
                else
                    region = 2;
                if ($urandom_range(0, 99) < odds[region])
                    {px.red, px.green, px.blue} = {COLOR_FULL, COLOR_FULL, COLOR_NONE};
                else if ($urandom_range(0, 3) == 0)
                    {px.red, px.green, px.blue} = 24'hFFFF00 ^ (24'h1 << $urandom_range(0, 23));
                else
                    {px.red, px.green, px.blue} = 24'($urandom);
                px.frame_end = (i == length - 1);
                send_pixel(px, emits, cmd);
                if (emits)
                    pending_cmds.push_back(cmd);
                random_pixels++;
            end
        end
        settle_block();
        quiet_phase = 1'b0;
    endtask

    // Stimulus: directed plan, then random phases.
    initial begin
        plan_row_t  directed_plan[$];
        bit         emits;
        drive_cmd_t cmd;

        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pixel.valid     = 1'b0;
        pixel.red       = '0;
        pixel.green     = '0;
        pixel.blue      = '0;
        pixel.frame_end = 1'b0;

        width_reg   = WIDTH_BITS'(RESET_FRAME_WIDTH);
        min_reg     = TOTAL_BITS'(RESET_MIN_TOTAL);
        max_reg     = TOTAL_BITS'(RESET_MAX_TOTAL);
        forward_reg = SPEED_BITS'(RESET_FORWARD_SPEED);
        turn_reg    = SPEED_BITS'(RESET_TURN_RATE);
        column      = '0;
        hits_left   = '0;
        hits_middle = '0;
        hits_right  = '0;
        last_cmd    = '0;

        // The first block runs on reset registers; the rest on a three-pixel row
        // with min 0, max 2 and full speed and turn (thirds are single columns).
        directed_plan = '{
            // A middle-dominated, too-small frame repeats the reset command: silent.
            plan_row(1'b0, 213, 24'h000000, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b1, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'h000000, 1'b1, CHECK_VALUE, 8'd0, 9'sd128),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b1, CHECK_NONE, 8'd0, 9'sd0),
            // One hit per third: above max, left wins the three-way tie.
            plan_row(1'b1, 1, 24'hFFFF00, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b1, CHECK_VALUE, 8'd0, 9'sd255),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'h000000, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'h000000, 1'b1, CHECK_VALUE, 8'd255, 9'sd255),
            plan_row(1'b0, 1, 24'h000000, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'h000000, 1'b1, CHECK_VALUE, 8'd255, 9'sd0),
            plan_row(1'b0, 2, 24'h000000, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b1, CHECK_VALUE, 8'd255, -9'sd255),
            // The fourth pixel wraps to column 0; total equals max exactly.
            plan_row(1'b0, 1, 24'hFFFF00, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 2, 24'h000000, 1'b0, CHECK_NONE, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFFFF00, 1'b1, CHECK_VALUE, 8'd255, 9'sd255),
            // Empty frame with total equal to min repeats the last command.
            plan_row(1'b0, 1, 24'h000000, 1'b1, CHECK_NONE, 8'd0, 9'sd0),
            // Colors one step away from yellow never count.
            plan_row(1'b0, 1, 24'hFFFF01, 1'b0, CHECK_MODEL, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFEFF00, 1'b0, CHECK_MODEL, 8'd0, 9'sd0),
            plan_row(1'b0, 1, 24'hFFFE00, 1'b1, CHECK_MODEL, 8'd0, 9'sd0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].reconfig) begin
                settle_block();
                apply_settings(12'd3, 24'd0, 24'd2, 8'd255, 8'd255);
            end
            for (int c = 0; c < directed_plan[i].copies; c++) begin
                send_pixel(directed_plan[i].px, emits, cmd);
                case (directed_plan[i].check)
                    CHECK_MODEL: if (emits) pending_cmds.push_back(cmd);
                    CHECK_VALUE: pending_cmds.push_back(directed_plan[i].cmd);
                    default: ;
                endcase
            end
        end
        settle_block();

        while (random_pixels < RANDOM_PIXELS)
            run_random_phase();

        if (fault_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Drive command receiver: random hold-off per transaction, plus one long stall.
    initial begin
        int gap;
        drive.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!stall_done && results_seen >= STALL_AFTER) begin
                gap        = LONG_STALL;
                stall_done = 1'b1;
            end
            else begin
                gap = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (gap > 0) begin
                drive.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            drive.ready <= 1'b1;
            do
                @(posedge clk);
            while (!drive.valid);
        end
    end

    // Compare every completed drive transaction against the oldest prediction.
    always @(posedge clk) begin
        drive_cmd_t want;
        if (rst_n && drive.valid && drive.ready) begin
            results_seen++;
            if (pending_cmds.size() == 0) begin
                $error("unexpected drive command: linear_speed %0d, angular_speed %0d",
                       drive.linear_speed, $signed(drive.angular_speed));
                fault_count++;
            end
            else begin
                want = pending_cmds.pop_front();
                if (drive.linear_speed !== want.linear_speed) begin
                    $error("linear_speed: expected %0d, actual %0d",
                           want.linear_speed, drive.linear_speed);
                    fault_count++;
                end
                if (drive.angular_speed !== want.angular_speed) begin
                    $error("angular_speed: expected %0d, actual %0d",
                           $signed(want.angular_speed), $signed(drive.angular_speed));
                    fault_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        #(8_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
sv/cbs_pkg.sv
sv/cbs_pixel_if.sv
sv/cbs_drive_if.sv
sv/color_blob_steering.sv
tb/tb_color_blob_steering.sv
